// File: hdl/heap_sort_engine_assert.svh
// Assertion helpers for the heap sort engine.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk, ignored while rst is high.
`define HSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, ignored while rst is high.
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hse_pkg.sv
package hse_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_KEY_WIDTH  = 32;
  localparam int PORT_KEY_WIDTH = 32;
  localparam int MODE_WIDTH     = 2;
  localparam int MODE_DESC      = 0;
  localparam int MODE_SIGNED    = 1;

  // strobe and flags of one result item handed to the output register
  typedef struct packed {
    logic load;
    logic last;
    logic overflow;
  } emit_t;

endpackage

// File: hdl/hse_ram.sv
module hse_ram #(
  parameter int WIDTH = hse_pkg::DEF_KEY_WIDTH,
  parameter int DEPTH = hse_pkg::DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/hse_ctrl.sv
module hse_ctrl #(
  parameter int CAPACITY  = hse_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = hse_pkg::DEF_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [hse_pkg::MODE_WIDTH-1:0] mode,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [KEY_WIDTH-1:0]           in_key,
  input  logic                           in_last,
  input  logic                           out_free,
  output hse_pkg::emit_t                 emit,
  output logic [KEY_WIDTH-1:0]           emit_key
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    S_LOAD    = 10'b0000000001,
    S_FETCH   = 10'b0000000010,
    S_VLATCH  = 10'b0000000100,
    S_RD_L    = 10'b0000001000,
    S_RD_R    = 10'b0000010000,
    S_CMP     = 10'b0000100000,
    S_SWAP_RD = 10'b0001000000,
    S_SWAP    = 10'b0010000000,
    S_EMIT_RD = 10'b0100000000,
    S_EMIT_LD = 10'b1000000000
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic                  dropped, dropped_next;
  logic [CW-1:0]         size, size_next;
  logic [AW-1:0]         node, node_next;
  logic [AW-1:0]         kidx, kidx_next;
  logic [AW-1:0]         eidx, eidx_next;
  logic                  sorting, sorting_next;
  logic [KEY_WIDTH-1:0]  v, v_next;
  logic [KEY_WIDTH-1:0]  lval, lval_next;
  logic [KEY_WIDTH-1:0]  top_val, top_val_next;

  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [KEY_WIDTH-1:0]  wdata, rdata;

  logic [CW:0]           left_w, right_w;
  logic                  has_left, has_right, pick_right, move_down;
  logic [KEY_WIDTH-1:0]  cval;
  logic [AW-1:0]         caddr;
  logic [CW-1:0]         cnt_inc;

  // true when x must come after y in the configured order
  function automatic logic goes_after(input logic [KEY_WIDTH-1:0] x,
                                      input logic [KEY_WIDTH-1:0] y,
                                      input logic [hse_pkg::MODE_WIDTH-1:0] m);
    logic [KEY_WIDTH-1:0] xa;
    logic [KEY_WIDTH-1:0] ya;
    xa = x;
    ya = y;
    if (m[hse_pkg::MODE_SIGNED]) begin
      xa[KEY_WIDTH-1] = ~x[KEY_WIDTH-1];
      ya[KEY_WIDTH-1] = ~y[KEY_WIDTH-1];
    end
    return m[hse_pkg::MODE_DESC] ? (xa < ya) : (xa > ya);
  endfunction

  hse_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign left_w     = (CW+1)'({node, 1'b0}) + (CW+1)'(1);
  assign right_w    = left_w + (CW+1)'(1);
  assign has_left   = left_w < {1'b0, size};
  assign has_right  = right_w < {1'b0, size};
  assign pick_right = has_right && goes_after(rdata, lval, mode);
  assign cval       = pick_right ? rdata : lval;
  assign caddr      = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign move_down  = goes_after(cval, v, mode);
  assign cnt_inc    = (count < CW'(CAPACITY)) ? count + CW'(1) : count;

  assign in_ready = (state == S_LOAD);
  assign emit_key = rdata;

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    size_next    = size;
    node_next    = node;
    kidx_next    = kidx;
    eidx_next    = eidx;
    sorting_next = sorting;
    v_next       = v;
    lval_next    = lval;
    top_val_next = top_val;
    we           = 1'b0;
    waddr        = node;
    wdata        = v;
    re           = 1'b0;
    raddr        = node;
    emit         = '0;

    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          count_next = cnt_inc;
          if (count < CW'(CAPACITY)) begin
            we    = 1'b1;
            waddr = count[AW-1:0];
            wdata = in_key;
          end else begin
            dropped_next = 1'b1;
          end
          if (in_last) begin
            if (cnt_inc >= CW'(2)) begin
              size_next    = cnt_inc;
              kidx_next    = AW'((cnt_inc >> 1) - CW'(1));
              sorting_next = 1'b0;
              state_next   = S_FETCH;
            end else begin
              eidx_next  = '0;
              state_next = S_EMIT_RD;
            end
          end
        end
      end
      S_FETCH: begin
        re         = 1'b1;
        raddr      = kidx;
        node_next  = kidx;
        state_next = S_VLATCH;
      end
      S_VLATCH: begin
        v_next     = rdata;
        state_next = S_RD_L;
      end
      S_RD_L: begin
        if (has_left) begin
          re         = 1'b1;
          raddr      = left_w[AW-1:0];
          state_next = S_RD_R;
        end else begin
          we    = 1'b1;
          waddr = node;
          wdata = v;
          if (node == '0) begin
            top_val_next = v;
          end
          state_next = S_SWAP_RD;
        end
      end
      S_RD_R: begin
        lval_next = rdata;
        if (has_right) begin
          re    = 1'b1;
          raddr = right_w[AW-1:0];
        end
        state_next = S_CMP;
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = node;
        if (move_down) begin
          wdata      = cval;
          node_next  = caddr;
          state_next = S_RD_L;
          if (node == '0) begin
            top_val_next = cval;
          end
        end else begin
          wdata      = v;
          state_next = S_SWAP_RD;
          if (node == '0) begin
            top_val_next = v;
          end
        end
      end
      S_SWAP_RD: begin
        re    = 1'b1;
        raddr = size[AW-1:0];
        state_next = S_SWAP;
      end
      S_SWAP: begin
        v_next     = rdata;
        we         = 1'b1;
        waddr      = size[AW-1:0];
        wdata      = top_val;
        node_next  = '0;
        state_next = S_RD_L;
      end
      S_EMIT_RD: begin
        re         = 1'b1;
        raddr      = eidx;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          emit.load     = 1'b1;
          emit.last     = (CW'(eidx) + CW'(1) == count);
          emit.overflow = dropped;
          if (emit.last) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = S_LOAD;
          end else begin
            eidx_next  = eidx + AW'(1);
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    // one sift finished: pick the next sift, the next swap, or emission
    if (state_next == S_SWAP_RD) begin
      if (!sorting && kidx != '0) begin
        kidx_next  = kidx - AW'(1);
        state_next = S_FETCH;
      end else if (sorting && size == CW'(1)) begin
        eidx_next  = '0;
        state_next = S_EMIT_RD;
      end else begin
        sorting_next = 1'b1;
        size_next    = size - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      sorting <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      sorting <= sorting_next;
    end
  end

  always_ff @(posedge clk) begin
    size    <= size_next;
    node    <= node_next;
    kidx    <= kidx_next;
    eidx    <= eidx_next;
    v       <= v_next;
    lval    <= lval_next;
    top_val <= top_val_next;
  end

endmodule

// File: hdl/heap_sort_engine.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------
// input     | in_valid / in_ready        | key, last
// output    | out_valid / out_ready      | sorted_key, last_out, overflow
// config    | cfg_valid / cfg_ready      | order_mode
//
// Keys are taken one per cycle while loading. After the last key the set is
// heapified and sorted in place: each sift fetches the value to sink, then per
// level it descends reads left, reads right, compares and writes back, and at a
// leaf writes back. Emission reads each key, loads it into the output register
// when free; input and config are held off from the last key until the final
// result is loaded. Reset is synchronous; only written entries are read.
module heap_sort_engine #(
  parameter int CAPACITY  = hse_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = hse_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hse_pkg::PORT_KEY_WIDTH-1:0]  key,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hse_pkg::PORT_KEY_WIDTH-1:0]  sorted_key,
  output logic                                last_out,
  output logic                                overflow,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hse_pkg::MODE_WIDTH-1:0]      order_mode
);

`include "heap_sort_engine_assert.svh"

  logic [hse_pkg::MODE_WIDTH-1:0] mode_reg;
  logic [63:0]                    key_ext;
  logic [KEY_WIDTH-1:0]           in_key;
  logic                           out_free;
  hse_pkg::emit_t                 emit;
  logic [KEY_WIDTH-1:0]           emit_key;
  logic [63:0]                    emit_ext;

  // keep only the low KEY_WIDTH bits of each key; zero-fill when wider
  assign key_ext  = 64'(key);
  assign in_key   = key_ext[KEY_WIDTH-1:0];
  assign emit_ext = 64'(emit_key);

  // take config only while keys are being taken; hold it off during sort and emission
  assign cfg_ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mode_reg <= order_mode;
    end
  end

  // output register: free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      sorted_key <= emit_ext[hse_pkg::PORT_KEY_WIDTH-1:0];
      last_out   <= emit.last;
      overflow   <= emit.overflow;
    end
  end

  hse_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode_reg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_key  (in_key),
    .in_last (last),
    .out_free(out_free),
    .emit    (emit),
    .emit_key(emit_key)
  );

  // hold off new keys while a set is being emitted
  `HSE_ASSERT_NOW(a_load_excl, emit.load, !in_ready, "result loaded while taking keys")
  // never overwrite a result that is still waiting
  `HSE_ASSERT_NOW(a_load_free, emit.load, !out_valid || out_ready, "output overwritten")
  // the final result reopens the input
  `HSE_ASSERT_NEXT(a_reopen, emit.load && emit.last, in_ready, "input not reopened")
  // a last key closes the input for the sort
  `HSE_ASSERT_NEXT(a_close, in_valid && in_ready && last, !in_ready, "input open after last")

endmodule

// File: tb/heap_sort_engine_test.sv
module heap_sort_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Order settings: bit MODE_DESC picks descending, bit MODE_SIGNED picks signed compare
  localparam logic [1:0] MODE_ASC_U  = 2'b00;
  localparam logic [1:0] MODE_DESC_U = 2'b01;
  localparam logic [1:0] MODE_ASC_S  = 2'b10;
  localparam logic [1:0] MODE_DESC_S = 2'b11;

  localparam int SET_LIMIT     = hse_pkg::DEF_CAPACITY;
  localparam int MAX_WAIT      = 14;
  // Cycles to hold after the final sorted item before touching the register
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 40;
  // Watchdog limit on cycles with no handshake at all; well above a full 64-key sort
  localparam int STALL_LIMIT   = 20000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 5;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] key;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] sorted_key;
  logic        last_out;
  logic        overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  order_mode;

  heap_sort_engine uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key        (key),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sorted_key (sorted_key),
    .last_out   (last_out),
    .overflow   (overflow),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .order_mode (order_mode)
  );

  // One item of the sorted run as it should leave the block
  typedef struct packed {
    logic [31:0] skey;
    logic        fin;
    logic        ovf;
  } sorted_item_t;

  // One row of the directed script; exp_* only count where pinned is set
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] k;
    logic        l;
    logic        pinned;
    logic [31:0] exp_key;
    logic        exp_last;
    logic        exp_ovf;
  } script_row_t;

  // Pinned rows are single-key sets, which must come back untouched
  script_row_t script_rows [0:22] = '{
    '{MODE_ASC_U,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{MODE_ASC_U,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{MODE_ASC_U,  32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_U,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_U,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_U,  32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_U,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_U, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_U, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_U, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_U, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_S,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_S,  32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_S,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_S,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_S,  32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_S, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_S, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_S, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_S, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_DESC_S, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    '{MODE_ASC_U,  32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{MODE_ASC_U,  32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
  };

  // Sorter shadow: the set being gathered, its drop flag and the active order
  logic [31:0]  gathered_keys [$];
  bit           gathered_dropped;
  logic [1:0]   active_order;
  sorted_item_t awaited_items [$];

  int  error_count;
  bit  input_held;   // in_valid still high from the item just taken
  bit  send_calm;    // sender runs without gaps while set
  bit  recv_calm;    // receiver runs without stalls while set

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // True when key a belongs behind key b in the active order
  function automatic bit goes_behind(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    x = a;
    y = b;
    if (active_order[hse_pkg::MODE_SIGNED]) begin
      x ^= 32'h8000_0000;
      y ^= 32'h8000_0000;
    end
    return active_order[hse_pkg::MODE_DESC] ? (x < y) : (x > y);
  endfunction

  // Account for one accepted item; on the final item sort the set and queue the run.
  // A pinned row supplies its own expected item instead of the computed one.
  function automatic void absorb_key(logic [31:0] k, logic l, bit pinned,
                                     sorted_item_t pinned_item);
    logic [31:0]  v;
    int           j;
    sorted_item_t item;
    if (gathered_keys.size() < SET_LIMIT) gathered_keys.push_back(k);
    else gathered_dropped = 1'b1;
    if (!l) return;
    // Insertion sort is enough: equal keys are bit-identical, so order among them is moot
    for (int i = 1; i < gathered_keys.size(); i++) begin
      v = gathered_keys[i];
      j = i;
      while (j > 0 && goes_behind(gathered_keys[j-1], v)) begin
        gathered_keys[j] = gathered_keys[j-1];
        j--;
      end
      gathered_keys[j] = v;
    end
    if (pinned) begin
      awaited_items.push_back(pinned_item);
    end else begin
      foreach (gathered_keys[i]) begin
        item.skey = gathered_keys[i];
        item.fin  = (i == gathered_keys.size() - 1);
        item.ovf  = gathered_dropped;
        awaited_items.push_back(item);
      end
    end
    gathered_keys.delete();
    gathered_dropped = 1'b0;
  endfunction

  // Offer one item, hold it until taken, then update the shadow
  task automatic push_key(logic [31:0] k, logic l, bit pinned, sorted_item_t pinned_item);
    int gap;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      if (input_held) in_valid <= 1'b0;
      input_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    key      <= k;
    last     <= l;
    in_valid <= 1'b1;
    input_held = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    absorb_key(k, l, pinned, pinned_item);
  endtask

  // Drop valid so the item just taken is not offered again
  task automatic release_input();
    if (input_held) in_valid <= 1'b0;
    input_held = 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every sorted item is back and the block has gone quiet
  task automatic settle();
    release_input();
    while (awaited_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(logic [1:0] m);
    settle();
    order_mode <= m;
    cfg_valid  <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    active_order = m;
  endtask

  // Mix of wide random keys, small repeated values and keys around the sign boundary
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: return 32'h7FFF_FFFC + $urandom_range(0, 7);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_set(int n);
    sorted_item_t none;
    none = '0;
    send_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) push_key(pick_key(), i == n - 1, 1'b0, none);
  endtask

  // Stimulus
  initial begin : stimulus
    logic [1:0]   phase_orders [0:NUM_PHASES-1];
    sorted_item_t pinned_item;
    int           sent;
    int           set_size;
    int           pick;
    phase_orders = '{MODE_ASC_U, MODE_DESC_S, MODE_ASC_S, MODE_DESC_U,
                     MODE_DESC_S, MODE_ASC_U, MODE_DESC_U, MODE_ASC_S};
    rst        = 1'b1;
    in_valid   = 1'b0;
    key        = '0;
    last       = 1'b0;
    cfg_valid  = 1'b0;
    order_mode = MODE_ASC_U;
    active_order     = MODE_ASC_U;
    gathered_dropped = 1'b0;
    input_held       = 1'b0;
    send_calm        = 1'b0;
    error_count      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script: extremes, duplicates, each order, single-key sets
    foreach (script_rows[r]) begin
      if (script_rows[r].mode != active_order) write_order(script_rows[r].mode);
      send_calm = ($urandom_range(0, 1) == 0);
      pinned_item.skey = script_rows[r].exp_key;
      pinned_item.fin  = script_rows[r].exp_last;
      pinned_item.ovf  = script_rows[r].exp_ovf;
      push_key(script_rows[r].k, script_rows[r].l, script_rows[r].pinned, pinned_item);
    end

    // Random phases, one order each; one full set and one overflowing set along the way
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_order(phase_orders[p]);
      if (p == 2) push_set(SET_LIMIT);
      // Overflow set: its final item lands beyond capacity and must still end the set
      if (p == 5) push_set(SET_LIMIT + 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) settle();
        pick = $urandom_range(0, 9);
        if (pick == 0) set_size = 1;
        else if (pick < 8) set_size = $urandom_range(2, 8);
        else set_size = $urandom_range(9, 20);
        push_set(set_size);
        sent += set_size;
      end
    end

    // Drain and report
    release_input();
    while (awaited_items.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("[heap_sort_engine] OK");
    else $display("[heap_sort_engine] ERROR");
    $finish;
  end

  // Output side: random back-pressure and comparison against the awaited run
  initial begin : collector
    sorted_item_t want;
    int           stall;
    out_ready = 1'b0;
    recv_calm = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_valid && out_ready));
      if (awaited_items.size() == 0) begin
        $error("unexpected sorted item: sorted_key %h last_out %b overflow %b",
               sorted_key, last_out, overflow);
        error_count++;
      end else begin
        want = awaited_items.pop_front();
        if (sorted_key !== want.skey) begin
          $error("sorted_key: expected %h, actual %h", want.skey, sorted_key);
          error_count++;
        end
        if (last_out !== want.fin) begin
          $error("last_out: expected %b, actual %b", want.fin, last_out);
          error_count++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %b, actual %b", want.ovf, overflow);
          error_count++;
        end
      end
      // Flip between stall-free stretches and random stalls now and then
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      stall = draw_wait(recv_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[heap_sort_engine] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
